>>> rtl/core/rcfd_pkg.sv
// Shared types and constants of the replay-checked frame decoder.
package rcfd_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int unsigned NODE_COUNT_DEF  = 256;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // Frame layout.
   localparam int unsigned HEADER_LEN   = 7;
   localparam int unsigned HOLD_W       = $clog2(HEADER_LEN);
   localparam int unsigned BURST_MAX    = HEADER_LEN - 1;
   localparam int unsigned ITEM_W       = $clog2(BURST_MAX + 1);
   localparam logic [7:0]  NODE_POS     = 8'd1;
   localparam logic [7:0]  LEN_BYTE_POS = 8'd6;
   localparam int unsigned COUNTER_POS  = 2;

   // Port widths.
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   // Configuration register indexes and reset values.
   localparam logic [1:0] CSR_VERSION_CODE = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD  = 2'd1;
   localparam logic [1:0] CSR_OUT_LIMIT    = 2'd2;
   localparam logic [7:0] VERSION_CODE_RST = 8'd1;
   localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd248;
   localparam logic [7:0] OUT_LIMIT_RST    = 8'd255;

   // Frame status codes reported on the status item.
   localparam logic [1:0] ST_V1        = 2'd0;
   localparam logic [1:0] ST_V0        = 2'd1;
   localparam logic [1:0] ST_REPLAY    = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   typedef enum logic [1:0] {
      MODE_UNDECIDED,
      MODE_V1,
      MODE_V0,
      MODE_REPLAY
   } frame_mode_type;

   typedef struct packed {
      logic [7:0] version_code;
      logic [7:0] max_payload;
      logic [7:0] out_limit;
   } cfg_type;

   // One queue entry: a burst of payload bytes, optionally followed by a status item.
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] data;
      logic [ITEM_W-1:0]         ndata;
      logic                      has_status;
      logic [1:0]                status;
      logic [7:0]                count;
   } q_entry_type;

endpackage

>>> rtl/core/rcfd_front.sv
// Front end: accepts frame bytes, decides the frame format and checks the replay table.
module rcfd_front
   import rcfd_pkg::*;
#(
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  total_len,
   input  logic        q_full,
   output logic        q_push,
   output q_entry_type q_entry
);

   localparam int unsigned NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   // Reciprocal of the node count, exact for every 8-bit node id.
   localparam int unsigned NODE_RECIP = (65536 / NODE_COUNT) + 1;

   logic [7:0]        pos_ff, pos_in;
   frame_mode_type    mode_ff, mode_in;
   logic [7:0]        emitted_ff, emitted_in;
   logic [7:0]        target_ff, target_in;
   logic [7:0]        hold_ff [HEADER_LEN];
   logic [NODE_COUNT-1:0] seen_ff;
   logic [31:0]       ctr_mem [NODE_COUNT];
   logic [31:0]       rd_ff;
   logic [NODE_W-1:0] node_ff;

   logic [7:0]        hold_now [HEADER_LEN];
   logic              accept;
   logic              last;
   logic              v1_ok;
   logic              replay;
   logic              table_we;
   logic [31:0]       counter;
   logic [7:0]        limit;
   logic [7:0]        avail;
   logic [7:0]        v0_len;
   logic [7:0]        v0_target;
   logic [7:0]        v1_target;
   logic [7:0]        v0_burst;
   logic [23:0]       node_prod;
   logic [7:0]        node_quot;
   logic [15:0]       node_back;
   logic [7:0]        node_full;
   logic [NODE_W-1:0] node_now;
   q_entry_type       entry;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign last       = ({1'b0, pos_ff} + 9'd1) >= {1'b0, total_len};
   assign counter    = {hold_ff[COUNTER_POS + 3], hold_ff[COUNTER_POS + 2],
                        hold_ff[COUNTER_POS + 1], hold_ff[COUNTER_POS]};

   // Node id reduced modulo the node count by reciprocal multiplication.
   assign node_prod = {16'd0, rx_byte} * 24'(NODE_RECIP);
   assign node_quot = node_prod[23:16];
   assign node_back = {8'd0, node_quot} * 16'(NODE_COUNT);
   assign node_full = rx_byte - node_back[7:0];
   assign node_now  = node_full[NODE_W-1:0];

   // Format decision, payload limits and the queue entry for this transaction.
   always_comb begin
      pos_in     = pos_ff;
      mode_in    = mode_ff;
      emitted_in = emitted_ff;
      target_in  = target_ff;
      entry      = '0;
      table_we   = 1'b0;
      for (int i = 0; i < HEADER_LEN; i++) begin
         hold_now[i] = (pos_ff == 8'(i)) ? rx_byte : hold_ff[i];
      end
      limit     = (cfg.out_limit == 8'd0) ? 8'd0 : cfg.out_limit - 8'd1;
      v1_ok     = (pos_ff == LEN_BYTE_POS) && (hold_now[0] == cfg.version_code) &&
                  (rx_byte <= cfg.max_payload) &&
                  ((rx_byte + 8'(HEADER_LEN)) == total_len);
      replay    = seen_ff[node_ff] && (counter <= rd_ff);
      avail     = total_len - 8'd1;
      v0_len    = (hold_now[0] > avail) ? avail : hold_now[0];
      v0_target = (v0_len > limit) ? limit : v0_len;
      v1_target = (rx_byte > limit) ? limit : rx_byte;
      v0_burst  = (pos_ff < v0_target) ? pos_ff : v0_target;

      if (accept) begin
         case (mode_ff)
            MODE_UNDECIDED: begin
               // Decide on the length byte or on an early last byte.
               if ((pos_ff >= LEN_BYTE_POS || last) && total_len != 8'd0) begin
                  if (v1_ok && replay) begin
                     mode_in = MODE_REPLAY;
                  end else if (v1_ok) begin
                     mode_in   = MODE_V1;
                     target_in = v1_target;
                     table_we  = 1'b1;
                  end else begin
                     // Held v0 payload bytes go out as one burst.
                     mode_in    = MODE_V0;
                     target_in  = v0_target;
                     emitted_in = v0_burst;
                     for (int i = 0; i < BURST_MAX; i++) begin
                        entry.data[i] = hold_now[i + 1];
                     end
                     entry.ndata = v0_burst[ITEM_W-1:0];
                  end
               end
            end
            MODE_V1, MODE_V0: begin
               if (emitted_ff < target_ff) begin
                  entry.data[0] = rx_byte;
                  entry.ndata   = ITEM_W'(1);
                  emitted_in    = emitted_ff + 8'd1;
               end
            end
            default: begin
               // A replayed frame is consumed without payload.
            end
         endcase

         // The frame's last byte closes it with a status item.
         if (last) begin
            entry.has_status = 1'b1;
            entry.count      = emitted_in;
            case (mode_in)
               MODE_V1:        entry.status = ST_V1;
               MODE_V0:        entry.status = ST_V0;
               MODE_REPLAY:    entry.status = ST_REPLAY;
               default:        entry.status = ST_MALFORMED;
            endcase
            pos_in     = '0;
            mode_in    = MODE_UNDECIDED;
            emitted_in = '0;
            target_in  = '0;
         end else begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   assign q_push  = accept && (entry.ndata != '0 || entry.has_status);
   assign q_entry = entry;

   // Frame state and the node-seen bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         mode_ff    <= MODE_UNDECIDED;
         emitted_ff <= '0;
         target_ff  <= '0;
         seen_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         mode_ff    <= mode_in;
         emitted_ff <= emitted_in;
         target_ff  <= target_in;
         if (table_we) begin
            seen_ff[node_ff] <= 1'b1;
         end
      end
   end

   // Header bytes are held until the format is known.
   always_ff @(posedge clock) begin
      if (accept && mode_ff == MODE_UNDECIDED && pos_ff < 8'(HEADER_LEN)) begin
         hold_ff[pos_ff[HOLD_W-1:0]] <= rx_byte;
      end
   end

   // The last counter of the node is fetched as soon as the node id arrives.
   always_ff @(posedge clock) begin
      if (accept && mode_ff == MODE_UNDECIDED && pos_ff == NODE_POS) begin
         rd_ff   <= ctr_mem[node_now];
         node_ff <= node_now;
      end
   end

   // An accepted v1 frame stores its counter.
   always_ff @(posedge clock) begin
      if (table_we) begin
         ctr_mem[node_ff] <= counter;
      end
   end

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= target_ff)
      else $error("front emitted more payload bytes than the frame target");

   a_decided_past_header: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_UNDECIDED) |-> (pos_ff >= 8'(HEADER_LEN)))
      else $error("frame mode decided before the header was complete");

   a_table_write_v1: assert property (@(posedge clock) disable iff (reset)
      table_we |=> (mode_ff == MODE_V1 || pos_ff == 8'd0))
      else $error("replay table written for a frame that is not accepted as v1");

endmodule

>>> rtl/core/rcfd_queue.sv
// Short queue of result bursts between the front end and the back end.
module rcfd_queue
   import rcfd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output q_entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   q_entry_type      store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill-count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/rcfd_back.sv
// Back end: expands queued bursts into result transactions, one per cycle unless the receiver stalls.
module rcfd_back
   import rcfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  q_entry_type           head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [ITEM_W-1:0] idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff;
   logic              out_dv_ff;
   logic              out_last_ff;
   logic [1:0]        out_status_ff;
   logic [7:0]        out_count_ff;
   logic              is_data;
   logic              last_item;
   logic              load;

   assign is_data   = idx_ff < head.ndata;
   assign last_item = is_data ? ((idx_ff == head.ndata - ITEM_W'(1)) && !head.has_status)
                              : 1'b1;
   assign load      = q_valid && (!out_valid_ff || rsp_tready);
   assign q_pop     = load && last_item;

   // Item index within the head entry and the output register valid.
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = last_item ? '0 : idx_ff + ITEM_W'(1);
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= is_data ? head.data[idx_ff] : 8'd0;
         out_dv_ff     <= is_data;
         out_last_ff   <= !is_data;
         out_status_ff <= is_data ? ST_V1 : head.status;
         out_count_ff  <= is_data ? 8'd0 : head.count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_count_ff, out_status_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_dv_ff;

   a_status_not_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> !out_dv_ff)
      else $error("status transaction flagged as payload");

   a_data_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dv_ff) |-> (out_status_ff == ST_V1 && out_count_ff == 8'd0))
      else $error("payload transaction carries status fields");

   a_partial_entry_held: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> q_valid)
      else $error("queue entry left the head before it was fully expanded");

endmodule

>>> rtl/core/replay_checked_frame_decoder.sv
// Top level of the replay-checked frame decoder: configuration registers and block wiring.
// The first result transaction of a byte passes through the queue storage and the back end's
// output register before it is presented. Bytes are taken one per cycle while the queue
// has room; results leave one per cycle while the receiver is ready, so a v0 decision burst
// of up to seven results keeps the back end busy until the whole burst has left.
// Reset is synchronous: configuration returns to defaults and all node-seen bits clear at
// once; the counter memory is not cleared and its value is used only for nodes already seen.
module replay_checked_frame_decoder
   import rcfd_pkg::*;
#(
   parameter int unsigned NODE_COUNT  = NODE_COUNT_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // rx_byte[7:0], total_len[15:8]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte[7:0], frame_status[9:8],
                                              // payload_count[17:10], zero[23:18]
   output logic                  rsp_tlast,   // frame_done
   output logic                  rsp_tuser    // data_valid
);

   cfg_type     cfg_ff;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   q_entry_type q_entry;
   q_entry_type q_head;

   // Configuration registers, written without handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version_code <= VERSION_CODE_RST;
         cfg_ff.max_payload  <= MAX_PAYLOAD_RST;
         cfg_ff.out_limit    <= OUT_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERSION_CODE: cfg_ff.version_code <= csr_wdata;
            CSR_MAX_PAYLOAD:  cfg_ff.max_payload  <= csr_wdata;
            CSR_OUT_LIMIT:    cfg_ff.out_limit    <= csr_wdata;
            default: begin
               // Unmapped index: the write is dropped.
            end
         endcase
      end
   end

   rcfd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata[7:0]),
      .total_len  (req_tdata[15:8]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   rcfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   rcfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the replay-checked frame decoder: stimulus, predictor and checker.
module testbench;
   import rcfd_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int HOLDOFF_CYCLES = 100;
   localparam int DRAIN_LIMIT    = 5000;

   // One expected or observed result transaction, split into its fields.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       data_valid;
      logic       frame_done;
      logic [1:0] frame_status;
      logic [7:0] payload_count;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = CSR_VERSION_CODE;
   logic [7:0]            csr_wdata = 8'd0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // rx_byte[7:0], total_len[15:8]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_byte[7:0], frame_status[9:8],
                                            // payload_count[17:10], zero[23:18]
   logic                  rsp_tlast;        // frame_done
   logic                  rsp_tuser;        // data_valid

   // Shared run state.
   frame_result_type pending_results[$];
   int  failures = 0;
   int  bytes_sent = 0;
   int  results_checked = 0;
   int  frames_v1 = 0;
   int  frames_v0 = 0;
   int  frames_replay = 0;
   int  frames_malformed = 0;
   logic idle_enable = 1'b1;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  sink_wait = 0;

   // Decoder state as the predictor tracks it.
   logic [7:0]     cfg_version;
   logic [7:0]     cfg_max_payload;
   logic [7:0]     cfg_out_limit;
   logic [7:0]     frame_pos;
   logic [7:0]     header_bytes [HEADER_LEN];
   frame_mode_type frame_mode;
   logic [7:0]     sent_count;
   logic [7:0]     payload_goal;
   logic           node_known [NODE_COUNT_DEF];
   logic [31:0]    node_counter [NODE_COUNT_DEF];

   replay_checked_frame_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Put the predictor into its post-reset state.
   task automatic reset_decoder_model();
      int i;
      cfg_version     = VERSION_CODE_RST;
      cfg_max_payload = MAX_PAYLOAD_RST;
      cfg_out_limit   = OUT_LIMIT_RST;
      frame_pos       = 8'd0;
      frame_mode      = MODE_UNDECIDED;
      sent_count      = 8'd0;
      payload_goal    = 8'd0;
      for (i = 0; i < HEADER_LEN; i++) header_bytes[i] = 8'd0;
      for (i = 0; i < NODE_COUNT_DEF; i++) begin
         node_known[i]   = 1'b0;
         node_counter[i] = 32'd0;
      end
   endtask

   // An output buffer of out_limit bytes holds at most out_limit - 1 payload bytes.
   function automatic logic [7:0] clamp_to_limit(input logic [7:0] n);
      logic [7:0] room;
      room = (cfg_out_limit == 8'd0) ? 8'd0 : cfg_out_limit - 8'd1;
      return (n > room) ? room : n;
   endfunction

   task automatic expect_result(input logic [7:0] data, input logic valid, input logic done,
                                input logic [1:0] status, input logic [7:0] count);
      frame_result_type r;
      r.out_byte      = data;
      r.data_valid    = valid;
      r.frame_done    = done;
      r.frame_status  = status;
      r.payload_count = count;
      pending_results.push_back(r);
      if (done) begin
         case (status)
            ST_V1:     frames_v1++;
            ST_V0:     frames_v0++;
            ST_REPLAY: frames_replay++;
            default:   frames_malformed++;
         endcase
      end
   endtask

   task automatic end_frame_state();
      frame_pos    = 8'd0;
      frame_mode   = MODE_UNDECIDED;
      sent_count   = 8'd0;
      payload_goal = 8'd0;
   endtask

   // Predict the result transactions caused by one accepted byte.
   task automatic decode_byte(input logic [7:0] rx_byte, input logic [7:0] total_len);
      logic        frame_last;
      logic [7:0]  lead;
      logic [31:0] counter;
      int          node;
      int          i;
      logic [1:0]  status;
      frame_last = ({1'b0, frame_pos} + 9'd1) >= {1'b0, total_len};
      if (frame_mode == MODE_UNDECIDED) begin
         if (frame_pos < HEADER_LEN) header_bytes[frame_pos[HOLD_W-1:0]] = rx_byte;
         if (frame_pos >= LEN_BYTE_POS || frame_last) begin
            // A zero length ends the frame as malformed before any decision.
            if (total_len == 8'd0) begin
               expect_result(8'd0, 1'b0, 1'b1, ST_MALFORMED, 8'd0);
               end_frame_state();
               return;
            end
            if (frame_pos == LEN_BYTE_POS && header_bytes[0] == cfg_version &&
                header_bytes[LEN_BYTE_POS] <= cfg_max_payload &&
                8'(8'(HEADER_LEN) + header_bytes[LEN_BYTE_POS]) == total_len) begin
               node    = int'(header_bytes[NODE_POS]) % NODE_COUNT_DEF;
               counter = {header_bytes[COUNTER_POS + 3], header_bytes[COUNTER_POS + 2],
                          header_bytes[COUNTER_POS + 1], header_bytes[COUNTER_POS]};
               if (node_known[node] && counter <= node_counter[node]) begin
                  frame_mode = MODE_REPLAY;
               end else begin
                  node_known[node]   = 1'b1;
                  node_counter[node] = counter;
                  frame_mode         = MODE_V1;
                  payload_goal       = clamp_to_limit(header_bytes[LEN_BYTE_POS]);
               end
            end else begin
               // Legacy format: lead byte is the length, clamped to what the frame holds.
               lead = header_bytes[0];
               if (lead > total_len - 8'd1) lead = total_len - 8'd1;
               frame_mode   = MODE_V0;
               payload_goal = clamp_to_limit(lead);
               for (i = 1; i <= int'(frame_pos) && i < HEADER_LEN; i++) begin
                  if (sent_count < payload_goal) begin
                     expect_result(header_bytes[i], 1'b1, 1'b0, ST_V1, 8'd0);
                     sent_count++;
                  end
               end
            end
         end
      end else if (frame_mode == MODE_V1 || frame_mode == MODE_V0) begin
         if (frame_pos >= ((frame_mode == MODE_V1) ? HEADER_LEN : 1) &&
             sent_count < payload_goal) begin
            expect_result(rx_byte, 1'b1, 1'b0, ST_V1, 8'd0);
            sent_count++;
         end
      end
      if (frame_last) begin
         status = (frame_mode == MODE_V1) ? ST_V1 :
                  (frame_mode == MODE_V0) ? ST_V0 : ST_REPLAY;
         expect_result(8'd0, 1'b0, 1'b1, status, sent_count);
         end_frame_state();
      end else begin
         frame_pos++;
      end
   endtask

   // Offer one byte, with an occasional idle burst first, and predict once it is taken.
   task automatic send_byte(input logic [7:0] value, input logic [7:0] total_len);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {total_len, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(value, total_len);
      bytes_sent++;
   endtask

   // Frame with the seven-byte header layout; payload bytes fill it up to total_len.
   task automatic send_header_frame(input logic [7:0] lead, input logic [7:0] node,
                                    input logic [31:0] counter, input logic [7:0] n,
                                    input logic [7:0] total_len);
      int i;
      send_byte(lead, total_len);
      send_byte(node, total_len);
      send_byte(counter[7:0], total_len);
      send_byte(counter[15:8], total_len);
      send_byte(counter[23:16], total_len);
      send_byte(counter[31:24], total_len);
      send_byte(n, total_len);
      for (i = HEADER_LEN; i < int'(total_len); i++) send_byte(8'($urandom), total_len);
   endtask

   task automatic send_v0_frame(input logic [7:0] lead, input logic [7:0] total_len);
      int i;
      send_byte(lead, total_len);
      for (i = 1; i < int'(total_len); i++) send_byte(8'($urandom), total_len);
   endtask

   // Mostly well-formed frames with random content, some broken ones and some noise.
   task automatic send_random_frame();
      logic [7:0]  node;
      logic [7:0]  n;
      logic [7:0]  total_len;
      logic [31:0] counter;
      int          kind;
      int          top;
      int          len;
      int          i;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         node = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0:       counter = $urandom;
            1:       counter = node_counter[node] - 32'($urandom_range(0, 3));
            default: counter = node_counter[node] + 32'($urandom_range(1, 1000));
         endcase
         top = ($urandom_range(0, 9) == 0) ? 40 : 8;
         if (top > int'(cfg_max_payload)) top = cfg_max_payload;
         n = 8'($urandom_range(0, top));
         send_header_frame(cfg_version, node, counter, n, 8'(HEADER_LEN) + n);
      end else if (kind <= 7) begin
         len = $urandom_range(1, 12);
         send_v0_frame($urandom_range(0, 1) ? 8'($urandom_range(0, len + 2)) : 8'($urandom),
                       8'(len));
      end else if (kind == 8) begin
         // Version byte right, length byte and frame length often inconsistent.
         n = 8'($urandom_range(0, 12));
         send_header_frame(cfg_version, 8'($urandom), $urandom, n,
                           8'(HEADER_LEN + $urandom_range(0, 12)));
      end else begin
         // Short frame whose length tag changes from byte to byte.
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) begin
            if (i == len - 1) total_len = 8'($urandom_range(1, i + 1));
            else total_len = 8'($urandom_range(i + 2, 255));
            send_byte(8'($urandom), total_len);
         end
      end
   endtask

   task automatic random_traffic(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_frame();
   endtask

   // Stop offering and let every expected result arrive, plus the pipeline latency.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_VERSION_CODE: cfg_version = value;
         CSR_MAX_PAYLOAD:  cfg_max_payload = value;
         CSR_OUT_LIMIT:    cfg_out_limit = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Directed frames: each format, a replay, edge values and the odd length cases.
   task automatic test_directed_frames();
      send_header_frame(VERSION_CODE_RST, 8'd0, 32'd5, 8'd0, 8'd7);
      send_header_frame(VERSION_CODE_RST, 8'd0, 32'd5, 8'd0, 8'd7);
      send_byte(8'hFF, 8'd1);
      send_byte(8'd3, 8'd255);
      send_byte(8'hAA, 8'd2);
      send_byte(8'd0, 8'd0);
      send_header_frame(VERSION_CODE_RST, 8'hFF, 32'hFFFF_FFFF, 8'd1, 8'd8);
   endtask

   // Receiver holds off long enough for the decoder to fill and stall its input.
   task automatic test_receiver_holdoff();
      wait_drained();
      hold_requests <= hold_requests + 1;
      send_header_frame(cfg_version, 8'd2, node_counter[2] + 32'd1, 8'd12, 8'd19);
      send_v0_frame(8'd14, 8'd14);
      wait_drained();
   endtask

   // Sweep the registers through their extremes with traffic under each setting.
   task automatic test_config_extremes();
      wait_drained();
      write_reg(CSR_VERSION_CODE, 8'hFF);
      write_reg(CSR_MAX_PAYLOAD, 8'd0);
      write_reg(CSR_OUT_LIMIT, 8'd1);
      random_traffic(8);
      wait_drained();
      write_reg(CSR_VERSION_CODE, 8'h00);
      write_reg(CSR_MAX_PAYLOAD, 8'd5);
      write_reg(CSR_OUT_LIMIT, 8'd0);
      random_traffic(6);
      wait_drained();
      write_reg(CSR_OUT_LIMIT, 8'd4);
      random_traffic(6);
      wait_drained();
      write_reg(CSR_VERSION_CODE, 8'h5A);
      write_reg(CSR_MAX_PAYLOAD, 8'd248);
      write_reg(CSR_OUT_LIMIT, 8'd255);
      random_traffic(6);
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate();
      idle_enable <= 1'b0;
      random_traffic(12);
   endtask

   // Receiver ready: long hold-offs on request, otherwise random stall bursts.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         sink_wait   <= HOLDOFF_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         sink_wait  <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: tdata %h tlast %b tuser %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            failures++;
         end else begin
            want = pending_results.pop_front();
            compare_field("out_byte", want.out_byte, rsp_tdata[7:0]);
            compare_field("data_valid", 8'(want.data_valid), 8'(rsp_tuser));
            compare_field("frame_done", 8'(want.frame_done), 8'(rsp_tlast));
            compare_field("frame_status", 8'(want.frame_status), 8'(rsp_tdata[9:8]));
            compare_field("payload_count", want.payload_count, rsp_tdata[17:10]);
            results_checked++;
         end
      end
   end

   initial begin
      int waited;
      reset_decoder_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      random_traffic(8);
      test_receiver_holdoff();
      test_config_extremes();
      test_full_rate();
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         failures++;
      end
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes; checked %0d results over %0d v1, %0d v0, %0d replayed",
               bytes_sent, results_checked, frames_v1, frames_v0, frames_replay);
      $display("and %0d malformed frames, under five register settings.", frames_malformed);
      if (failures == 0) begin
         $display("[replay_checked_frame_decoder] OK");
      end else begin
         $display("[replay_checked_frame_decoder] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $error("timeout with %0d results still expected", pending_results.size());
      $display("[replay_checked_frame_decoder] ERROR");
      $finish;
   end

endmodule
